// ===== sv/tma_pkg.sv =====
package tma_pkg;

   localparam int ADC_BITS = 12;
   localparam int ADC_FULL = 1 << ADC_BITS;
   localparam int MAX_WINDOW = 64;
   localparam int WIN_BITS = $clog2(MAX_WINDOW);
   localparam int LEN_BITS = 7;
   localparam int TEMP_BITS = 18;
   localparam int SUM_BITS = 25;
   localparam int QUO_BITS = SUM_BITS - 1;
   localparam int CNT_BITS = $clog2(QUO_BITS);

   localparam logic [LEN_BITS-1:0] WINDOW_RESET = LEN_BITS'(50);

   localparam longint TEMP_MAX = 131071;
   localparam longint TEMP_MIN = -131072;
   localparam longint unsigned LN2_Q32 = 64'd2977044472;

   typedef logic signed [TEMP_BITS-1:0] temp_type;
   typedef logic signed [SUM_BITS-1:0] sum_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOOKUP = 4'b0010,
      ST_DIV    = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   // natural log of n in Q32: integer part from the top set bit, fraction by squaring
   function automatic longint unsigned tma_ln_q32(input int unsigned n);
      int unsigned k;
      longint unsigned y;
      longint unsigned frac;
      int i;
      k = 0;
      frac = 0;
      while (k < 31 && (n >> (k + 1)) != 0)
         k = k + 1;
      y = (longint'(n) << 30) >> k;
      for (i = 0; i < 32; i = i + 1) begin
         y = (y * y) >> 30;
         frac = frac << 1;
         if (y >= 64'h8000_0000) begin
            y = y >> 1;
            frac = frac | 64'd1;
         end
      end
      return longint'(k) * LN2_Q32 + ((frac * LN2_Q32) >> 32);
   endfunction

   // beta-formula conversion of one code to 1/256 degree Celsius
   function automatic temp_type tma_convert(input int unsigned a);
      longint lx;
      longint d;
      longint v;
      longint r;
      longint unsigned den;
      longint unsigned rem;
      longint unsigned q;
      logic sat;
      int i;
      q = 0;
      sat = 1'b0;
      if (a != 0) begin
         lx = longint'(tma_ln_q32(ADC_FULL - a)) - longint'(tma_ln_q32(a));
         d = longint'(29815) * lx + (longint'(427500) <<< 32);
         if (d <= 0) begin
            sat = 1'b1;
         end else begin
            den = longint'(d);
            rem = 64'd32629536000;
            while (rem >= den) begin
               rem = rem - den;
               q = q + 1;
            end
            for (i = 0; i < 48; i = i + 1) begin
               rem = rem << 1;
               q = q << 1;
               if (rem >= den) begin
                  rem = rem - den;
                  q = q | 64'd1;
               end
            end
         end
      end
      if (q > 64'd10000000000000)
         sat = 1'b1;
      if (sat) begin
         r = TEMP_MAX;
      end else begin
         v = longint'(q * 64'd100) - 64'sd458269655040;
         if (v >= 0)
            r = (v + 64'sd3276800) / 64'sd6553600;
         else
            r = -((-v + 64'sd3276800) / 64'sd6553600);
         if (r > TEMP_MAX)
            r = TEMP_MAX;
         if (r < TEMP_MIN)
            r = TEMP_MIN;
      end
      return r[TEMP_BITS-1:0];
   endfunction

endpackage

// ===== sv/thermistor_moving_average.sv =====
// Thermistor converter with moving average. Each request carries a 12-bit ADC code that is
// looked up in a 4096-entry conversion ROM (NTC beta formula, B 4275, R0 100k, 25 C
// reference, built at elaboration) giving a signed temperature in 1/256 C; code 0 reads
// -273.15 C. The sample replaces the oldest entry of a ring of window_length entries, a
// running sum is updated, and the response carries the sample, the sum divided by the
// window (rounded toward zero) and a flag that is set once the ring has wrapped. A request
// goes through these steps: the ROM and ring reads are registered on acceptance, the sum is
// updated and the ring written, the restoring divider that shares one subtract-compare
// stage forms the quotient, and the response register is loaded once it is empty or being
// taken; while it waits for rsp_ready, the next request is held off. A window of 0 acts as
// 1 and one above 64 as 64. Writing window_length restarts the average: ring valid bits,
// sum, position and flag are cleared at once, with no clearing pass.
module thermistor_moving_average import tma_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [ADC_BITS-1:0]  req_adc_code,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output temp_type             rsp_current_temp,
   output temp_type             rsp_average_temp,
   output logic                 rsp_window_filled,
   input  logic                 csr_write_enable,
   input  logic [LEN_BITS-1:0]  csr_write_data
);

   temp_type rom_table [ADC_FULL];
   temp_type ring_mem [MAX_WINDOW];

   state_type state_ff, state_in;
   logic [LEN_BITS-1:0] wl_ff, wl_in;
   logic [WIN_BITS-1:0] wpos_ff, wpos_in;
   logic filled_ff, filled_in;
   logic [MAX_WINDOW-1:0] valid_ff, valid_in;
   sum_type sum_ff, sum_in;
   temp_type cur_ff, cur_in;
   logic neg_ff, neg_in;
   logic [QUO_BITS-1:0] quo_ff, quo_in;
   logic [WIN_BITS-1:0] rem_ff, rem_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   temp_type rsp_cur_ff, rsp_cur_in;
   temp_type rsp_avg_ff, rsp_avg_in;
   logic rsp_filled_ff, rsp_filled_in;

   temp_type rom_rd_ff;
   temp_type ring_rd_ff;
   logic ring_we;

   logic [LEN_BITS-1:0] len_eff;
   temp_type old_sample;
   sum_type sum_new;
   sum_type sum_mag;
   logic [WIN_BITS:0] trial;
   logic [LEN_BITS-1:0] next_pos;
   logic [QUO_BITS-1:0] quo_neg;
   logic req_accept;

   for (genvar i = 0; i < ADC_FULL; i++) begin : g_rom
      localparam temp_type ROM_ENTRY = tma_convert(i);
      assign rom_table[i] = ROM_ENTRY;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_current_temp = rsp_cur_ff;
   assign rsp_average_temp = rsp_avg_ff;
   assign rsp_window_filled = rsp_filled_ff;

   always_comb begin
      if (wl_ff == '0)
         len_eff = LEN_BITS'(1);
      else if (wl_ff > LEN_BITS'(MAX_WINDOW))
         len_eff = LEN_BITS'(MAX_WINDOW);
      else
         len_eff = wl_ff;
   end

   always_comb begin
      old_sample = valid_ff[wpos_ff] ? ring_rd_ff : '0;
      sum_new = sum_ff - SUM_BITS'(old_sample) + SUM_BITS'(rom_rd_ff);
      sum_mag = sum_new[SUM_BITS-1] ? -sum_new : sum_new;
      trial = {rem_ff, quo_ff[QUO_BITS-1]};
      next_pos = LEN_BITS'(wpos_ff) + LEN_BITS'(1);
      quo_neg = '0 - quo_ff;
   end

   always_comb begin
      state_in = state_ff;
      wl_in = wl_ff;
      wpos_in = wpos_ff;
      filled_in = filled_ff;
      valid_in = valid_ff;
      sum_in = sum_ff;
      cur_in = cur_ff;
      neg_in = neg_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_cur_in = rsp_cur_ff;
      rsp_avg_in = rsp_avg_ff;
      rsp_filled_in = rsp_filled_ff;
      ring_we = 1'b0;

      if (rsp_valid_ff && rsp_ready)
         rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid)
               state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            ring_we = 1'b1;
            valid_in[wpos_ff] = 1'b1;
            sum_in = sum_new;
            cur_in = rom_rd_ff;
            neg_in = sum_new[SUM_BITS-1];
            quo_in = sum_mag[QUO_BITS-1:0];
            rem_in = '0;
            cnt_in = '0;
            if (next_pos >= len_eff) begin
               wpos_in = '0;
               filled_in = 1'b1;
            end else begin
               wpos_in = next_pos[WIN_BITS-1:0];
            end
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if ({1'b0, trial} >= {1'b0, len_eff}) begin
               rem_in = WIN_BITS'(trial - len_eff[WIN_BITS:0]);
               quo_in = {quo_ff[QUO_BITS-2:0], 1'b1};
            end else begin
               rem_in = trial[WIN_BITS-1:0];
               quo_in = {quo_ff[QUO_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(QUO_BITS - 1))
               state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_cur_in = cur_ff;
               rsp_avg_in = neg_ff ? quo_neg[TEMP_BITS-1:0] : quo_ff[TEMP_BITS-1:0];
               rsp_filled_in = filled_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // restart the average
      if (csr_write_enable) begin
         wl_in = csr_write_data;
         valid_in = '0;
         sum_in = '0;
         wpos_in = '0;
         filled_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wl_ff <= WINDOW_RESET;
         wpos_ff <= '0;
         filled_ff <= 1'b0;
         valid_ff <= '0;
         sum_ff <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         wl_ff <= wl_in;
         wpos_ff <= wpos_in;
         filled_ff <= filled_in;
         valid_ff <= valid_in;
         sum_ff <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      rsp_cur_ff <= rsp_cur_in;
      rsp_avg_ff <= rsp_avg_in;
      rsp_filled_ff <= rsp_filled_in;
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rom_rd_ff <= rom_table[req_adc_code];
         ring_rd_ff <= ring_mem[wpos_ff];
      end
      if (ring_we)
         ring_mem[wpos_ff] <= rom_rd_ff;
   end

   a_wpos_in_window: assert property (@(posedge clock) disable iff (reset)
      {1'b0, wpos_ff} < len_eff)
      else $error("write position outside window");

   a_filled_clears_on_write: assert property (@(posedge clock) disable iff (reset)
      $fell(filled_ff) |-> ($past(csr_write_enable) || $past(reset)))
      else $error("filled flag dropped without a window write");

   a_accept_starts_lookup: assert property (@(posedge clock) disable iff (reset)
      req_accept && !csr_write_enable |=> (state_ff == ST_LOOKUP) && !req_ready)
      else $error("accepted request did not start a lookup");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> ({1'b0, rem_ff} < len_eff))
      else $error("divider remainder not below divisor");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside completion");

endmodule
